// ===== design/spft_pkg.sv =====
package spft_pkg;

	localparam int ID_W    = 32;
	localparam int KEY_W   = 64;
	localparam int FLAG_W  = 8;
	localparam int COUNT_W = 7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CHECK,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_FINISH,
		ST_OUT
	} state_t;

	localparam logic OP_QUERY = 1'b0;
	localparam logic OP_ADD   = 1'b1;

	function automatic logic [KEY_W-1:0] make_key(input logic [ID_W-1:0] a,
			input logic [ID_W-1:0] b);
		logic [KEY_W-1:0] k;
		if (a > b) begin
			k = {b, a};
		end else begin
			k = {a, b};
		end
		return k;
	endfunction

endpackage

// ===== design/spft_store.sv =====
module spft_store import spft_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [KEY_W-1:0]  wr_key,
	input  logic [FLAG_W-1:0] wr_flags,
	input  logic [AW-1:0]     rd_addr,
	output logic [KEY_W-1:0]  rd_key,
	output logic [FLAG_W-1:0] rd_flags
);

	logic [KEY_W+FLAG_W-1:0] mem [DEPTH];
	logic [KEY_W+FLAG_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_key, wr_flags};
		end
		rd_q <= mem[rd_addr];
	end

	assign rd_key   = rd_q[KEY_W+FLAG_W-1:FLAG_W];
	assign rd_flags = rd_q[FLAG_W-1:0];

endmodule

// ===== design/sorted_pair_flag_table.sv =====
// sorted pair flag table: keeps unordered 32-bit id pairs sorted by a 64-bit key
// (smaller id high), each with a flag byte, in one memory with a registered read.
// input channel: valid/stall with op, id_first, id_second, pair_flags.
// output channel: valid/stall with found, can_collide, table_full, entry_count.
// one item at a time: stall is high from the accepted transfer until its result
// has been taken and the block is back to idle.
// the binary search reads one memory slot per step, at most ceil(log2(count+1))
// steps and fewer when the key turns up early; an insert then moves every later
// entry up one slot, reading and then writing each in turn.
// reset empties the table (count to zero) and sets collide_mask to 1; memory
// contents are not cleared, and no data from a slot at or above the count is used.
// collide_mask is written with cfg_wr_en/cfg_wr_data; the user must do so only
// while the block is idle, which the block itself does not enforce.
// the result sits in an output register until the receiver takes it; while out_stall
// is high it holds and no new item is taken.
module sorted_pair_flag_table import spft_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [FLAG_W-1:0] cfg_wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              op,
	input  logic [ID_W-1:0]   id_first,
	input  logic [ID_W-1:0]   id_second,
	input  logic [FLAG_W-1:0] pair_flags,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              found,
	output logic              can_collide,
	output logic              table_full,
	output logic [COUNT_W-1:0] entry_count
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	state_t state_q, state_d;

	logic [FLAG_W-1:0] mask_q;
	logic [CW-1:0]     count_q;
	logic              op_q;
	logic [KEY_W-1:0]  key_q;
	logic [FLAG_W-1:0] flags_q;
	logic [CW-1:0]     lo_q, hi_q, idx_q;
	logic              found_q, collide_q, full_q;

	logic              wr_en;
	logic [AW-1:0]     wr_addr, rd_addr;
	logic [KEY_W-1:0]  wr_key, rd_key;
	logic [FLAG_W-1:0] wr_flags, rd_flags;
	logic [CW:0]       mid_sum;
	logic [CW-1:0]     mid;
	logic [CW-1:0]     lo_nx, hi_nx;
	logic              hit;
	logic              do_ins;

	spft_store #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_key  (wr_key),
		.wr_flags(wr_flags),
		.rd_addr (rd_addr),
		.rd_key  (rd_key),
		.rd_flags(rd_flags)
	);

	assign mid_sum = ({1'b0, lo_q} + {1'b0, hi_q}) >> 1;
	assign mid     = mid_sum[CW-1:0];
	// probed slot is always below the count, so a key match is a hit
	assign hit     = (rd_key == key_q);
	assign do_ins  = (op_q == OP_ADD) && !found_q && (count_q != DEPTH_C);

	always_comb begin
		lo_nx = lo_q;
		hi_nx = hi_q;
		if (rd_key < key_q) begin
			lo_nx = idx_q + CW'(1);
		end else begin
			hi_nx = idx_q;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_d = (count_q == '0) ? ST_FINISH : ST_PROBE;
			ST_PROBE:    state_d = ST_CHECK;
			ST_CHECK: begin
				if (hit || lo_nx == hi_nx) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_PROBE;
				end
			end
			ST_SHIFT_RD: state_d = ST_SHIFT_WR;
			ST_SHIFT_WR: state_d = (idx_q - CW'(1) == lo_q) ? ST_OUT : ST_SHIFT_RD;
			ST_FINISH: begin
				if (do_ins && count_q != lo_q) begin
					state_d = ST_SHIFT_RD;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_OUT:      if (!out_stall) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = lo_q[AW-1:0];
		wr_key   = key_q;
		wr_flags = flags_q;
		rd_addr  = mid[AW-1:0];
		case (state_q)
			ST_SHIFT_RD: rd_addr = AW'(idx_q - CW'(1));
			ST_SHIFT_WR: begin
				// entry read in the previous cycle moves up one slot
				wr_en    = 1'b1;
				wr_addr  = idx_q[AW-1:0];
				wr_key   = rd_key;
				wr_flags = rd_flags;
			end
			ST_OUT: begin
				// update in place, or the new key into its freed slot
				if (op_q == OP_ADD && (found_q || !full_q)) begin
					wr_en = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mask_q  <= FLAG_W'(1);
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				mask_q <= cfg_wr_data;
			end
			if (state_q == ST_FINISH && do_ins) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				op_q      <= op;
				key_q     <= make_key(id_first, id_second);
				flags_q   <= pair_flags;
				lo_q      <= '0;
				hi_q      <= count_q;
				found_q   <= 1'b0;
				collide_q <= 1'b0;
				full_q    <= 1'b0;
			end
			ST_PROBE: idx_q <= mid;
			ST_CHECK: begin
				if (hit) begin
					found_q   <= 1'b1;
					lo_q      <= idx_q;
					collide_q <= (op_q == OP_QUERY) && ((rd_flags & mask_q) != '0);
				end else begin
					lo_q <= lo_nx;
					hi_q <= hi_nx;
				end
			end
			ST_SHIFT_WR: idx_q <= idx_q - CW'(1);
			ST_FINISH: begin
				full_q <= op_q == OP_ADD && !found_q && count_q == DEPTH_C;
				idx_q  <= count_q;
			end
			default: ;
		endcase
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = (state_q == ST_OUT);
	assign found       = found_q;
	assign can_collide = collide_q;
	assign table_full  = full_q;
	assign entry_count = COUNT_W'(count_q);

endmodule
